[sv/infix_to_postfix_converter_defines.svh]
// assertion macros used by the converter datapath
`ifndef INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define I2P_CHECK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition in one cycle forces a consequence in the next
`define I2P_CHECK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/i2p_pkg.sv]
package i2p_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int IDX_W       = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int MAX_RESULTS = 34;
   localparam int RCNT_W      = $clog2(MAX_RESULTS + 1);

   localparam logic [7:0] CH_OPEN  = 8'h28;
   localparam logic [7:0] CH_CLOSE = 8'h29;
   localparam logic [7:0] CH_MUL   = 8'h2a;
   localparam logic [7:0] CH_ADD   = 8'h2b;
   localparam logic [7:0] CH_SUB   = 8'h2d;
   localparam logic [7:0] CH_DIV   = 8'h2f;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_NUL   = 8'h00;

   typedef enum logic [2:0] {
      OP_OPEN = 3'd0,
      OP_ADD  = 3'd1,
      OP_SUB  = 3'd2,
      OP_MUL  = 3'd3,
      OP_DIV  = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_OPERAND,
      KIND_OPEN,
      KIND_CLOSE,
      KIND_OPER
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK              = 2'd0,
      ST_OVERFLOW        = 2'd1,
      ST_UNMATCHED_CLOSE = 2'd2,
      ST_UNMATCHED_OPEN  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      EMIT_NONE,
      EMIT_CHAR,
      EMIT_SPACE,
      EMIT_TOP
   } emit_sel_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_TOKEN,
      S_BODY,
      S_BODY_SP,
      S_TAIL,
      S_FLUSH,
      S_FLUSH_SP,
      S_END
   } state_type;

   typedef struct packed {
      logic         load;
      emit_sel_type emit;
      logic         push;
      logic         pop;
      logic         set_operand;
      logic         clr_operand;
      logic         set_sign;
      logic         clr_sign;
      logic         finish;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     last;
      logic     in_operand;
      logic     empty;
      logic     top_open;
      logic     top_pops;
      logic     emit_ok;
      logic     fin_ok;
   } stat_type;

   function automatic logic [1:0] prec(input opcode_type op);
      case (op)
         OP_MUL, OP_DIV: prec = 2'd2;
         OP_ADD, OP_SUB: prec = 2'd1;
         default:        prec = 2'd0;
      endcase
   endfunction

   function automatic logic [7:0] op_symbol(input opcode_type op);
      case (op)
         OP_ADD:  op_symbol = CH_ADD;
         OP_SUB:  op_symbol = CH_SUB;
         OP_MUL:  op_symbol = CH_MUL;
         OP_DIV:  op_symbol = CH_DIV;
         default: op_symbol = CH_OPEN;
      endcase
   endfunction

   // a '-' where a sign may stand is part of the operand
   function automatic kind_type char_kind(input logic [7:0] ch, input logic sign_ok);
      case (ch)
         CH_OPEN:                 char_kind = KIND_OPEN;
         CH_CLOSE:                char_kind = KIND_CLOSE;
         CH_ADD, CH_MUL, CH_DIV:  char_kind = KIND_OPER;
         CH_SUB:                  char_kind = sign_ok ? KIND_OPERAND : KIND_OPER;
         default:                 char_kind = KIND_OPERAND;
      endcase
   endfunction

   function automatic opcode_type char_op(input logic [7:0] ch);
      case (ch)
         CH_ADD:  char_op = OP_ADD;
         CH_SUB:  char_op = OP_SUB;
         CH_MUL:  char_op = OP_MUL;
         CH_DIV:  char_op = OP_DIV;
         default: char_op = OP_OPEN;
      endcase
   endfunction

endpackage

[sv/i2p_ctrl.sv]
module i2p_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output i2p_pkg::cmd_type   cmd,
   input  i2p_pkg::stat_type  stat
);
   import i2p_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.emit   = EMIT_NONE;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_TOKEN;
            end
         end
         S_TOKEN: begin
            if (stat.kind == KIND_OPERAND) begin
               if (stat.emit_ok) begin
                  cmd.emit        = EMIT_CHAR;
                  cmd.set_operand = 1'b1;
                  cmd.clr_sign    = 1'b1;
                  state_in        = stat.last ? S_TAIL : S_END;
               end
            end else if (stat.in_operand) begin
               // an operator or paren ends the open operand token
               if (stat.emit_ok) begin
                  cmd.emit        = EMIT_SPACE;
                  cmd.clr_operand = 1'b1;
                  state_in        = S_BODY;
               end
            end else begin
               state_in = S_BODY;
            end
         end
         S_BODY: begin
            case (stat.kind)
               KIND_OPEN: begin
                  cmd.push     = 1'b1;
                  cmd.set_sign = 1'b1;
                  state_in     = stat.last ? S_TAIL : S_END;
               end
               KIND_CLOSE: begin
                  if (stat.empty) begin
                     cmd.clr_sign = 1'b1;
                     state_in     = stat.last ? S_TAIL : S_END;
                  end else if (stat.top_open) begin
                     cmd.pop      = 1'b1;
                     cmd.clr_sign = 1'b1;
                     state_in     = stat.last ? S_TAIL : S_END;
                  end else if (stat.emit_ok) begin
                     cmd.emit = EMIT_TOP;
                     cmd.pop  = 1'b1;
                     state_in = S_BODY_SP;
                  end
               end
               KIND_OPER: begin
                  if (!stat.empty && stat.top_pops) begin
                     if (stat.emit_ok) begin
                        cmd.emit = EMIT_TOP;
                        cmd.pop  = 1'b1;
                        state_in = S_BODY_SP;
                     end
                  end else begin
                     cmd.push     = 1'b1;
                     cmd.clr_sign = 1'b1;
                     state_in     = stat.last ? S_TAIL : S_END;
                  end
               end
               default: begin
                  state_in = S_END;
               end
            endcase
         end
         S_BODY_SP: begin
            if (stat.emit_ok) begin
               cmd.emit = EMIT_SPACE;
               state_in = S_BODY;
            end
         end
         S_TAIL: begin
            if (stat.in_operand) begin
               if (stat.emit_ok) begin
                  cmd.emit        = EMIT_SPACE;
                  cmd.clr_operand = 1'b1;
                  state_in        = S_FLUSH;
               end
            end else begin
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            if (stat.empty) begin
               state_in = S_END;
            end else if (stat.top_open) begin
               // leftover open paren is dropped, its error was set on load
               cmd.pop = 1'b1;
            end else if (stat.emit_ok) begin
               cmd.emit = EMIT_TOP;
               cmd.pop  = 1'b1;
               state_in = S_FLUSH_SP;
            end
         end
         S_FLUSH_SP: begin
            if (stat.emit_ok) begin
               cmd.emit = EMIT_SPACE;
               state_in = S_FLUSH;
            end
         end
         S_END: begin
            if (stat.fin_ok) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
               if (!stat.last) begin
                  req_tready = 1'b1;
                  if (req_tvalid) begin
                     cmd.load = 1'b1;
                     state_in = S_TOKEN;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

[sv/i2p_datapath.sv]
`include "infix_to_postfix_converter_defines.svh"

module i2p_datapath (
   input  logic               clock,
   input  logic               reset,
   input  logic [7:0]         req_tdata,
   input  logic               req_tlast,
   input  i2p_pkg::cmd_type   cmd,
   output i2p_pkg::stat_type  stat,
   input  logic               rsp_tready,
   output logic               rsp_tvalid,
   output logic [7:0]         rsp_tdata,
   output logic               rsp_tlast,
   output logic [1:0]         rsp_tuser
);
   import i2p_pkg::*;

   logic [7:0]        char_ff;
   logic              last_ff;
   kind_type          kind_ff;
   opcode_type        op_ff;
   status_type        err_ff;
   status_type        err_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  open_ff;
   logic              operand_ff;
   logic              sign_ff;
   opcode_type        stack_ff [STACK_DEPTH];
   opcode_type        top_ff;
   logic [RCNT_W-1:0] rcnt_ff;
   logic              pend_valid_ff;
   logic [7:0]        pend_char_ff;
   logic              out_valid_ff;
   logic [7:0]        out_char_ff;
   logic              out_last_ff;
   status_type        out_status_ff;

   kind_type          req_kind;
   opcode_type        req_op;
   logic              full;
   logic              empty;
   logic              top_open;
   logic [CNT_W-1:0]  below_cnt;
   logic [CNT_W-1:0]  open_after;
   status_type        err_char;
   status_type        err_flush;
   logic [7:0]        emit_char;
   logic              capped;
   logic              do_emit;
   logic              out_free;
   logic              move_emit;
   logic              move_fin;
   logic              do_push;

   assign req_kind  = char_kind(req_tdata, sign_ff);
   assign req_op    = char_op(req_tdata);
   assign full      = count_ff == CNT_W'(STACK_DEPTH);
   assign empty     = count_ff == '0;
   assign top_open  = top_ff == OP_OPEN;
   assign below_cnt = count_ff - CNT_W'(2);

   // the item's final status is known up front from the stack and paren counts
   always_comb begin
      err_char   = ST_OK;
      open_after = open_ff;
      case (req_kind)
         KIND_OPEN: begin
            if (full) begin
               err_char = ST_OVERFLOW;
            end else begin
               open_after = open_ff + CNT_W'(1);
            end
         end
         KIND_CLOSE: begin
            if (open_ff == '0) begin
               err_char = ST_UNMATCHED_CLOSE;
            end else begin
               open_after = open_ff - CNT_W'(1);
            end
         end
         KIND_OPER: begin
            // a full stack only overflows when nothing pops first
            if (full && (top_open || prec(top_ff) < prec(req_op))) begin
               err_char = ST_OVERFLOW;
            end
         end
         default: begin
            err_char = ST_OK;
         end
      endcase
      err_flush = (req_tlast && open_after != '0) ? ST_UNMATCHED_OPEN : ST_OK;
      if (err_ff != ST_OK) begin
         err_in = err_ff;
      end else if (err_char != ST_OK) begin
         err_in = err_char;
      end else begin
         err_in = err_flush;
      end
   end

   always_comb begin
      case (cmd.emit)
         EMIT_CHAR:  emit_char = char_ff;
         EMIT_SPACE: emit_char = CH_SPACE;
         EMIT_TOP:   emit_char = op_symbol(top_ff);
         default:    emit_char = CH_NUL;
      endcase
   end

   // the newest result waits in the pending stage so that out_last can be set on it
   assign capped    = rcnt_ff >= RCNT_W'(MAX_RESULTS);
   assign do_emit   = (cmd.emit != EMIT_NONE) && !capped;
   assign out_free  = !out_valid_ff || rsp_tready;
   assign move_emit = do_emit && pend_valid_ff;
   assign move_fin  = cmd.finish && (pend_valid_ff || last_ff);
   assign do_push   = cmd.push && !full;

   always_comb begin
      stat            = '0;
      stat.kind       = kind_ff;
      stat.last       = last_ff;
      stat.in_operand = operand_ff;
      stat.empty      = empty;
      stat.top_open   = top_open;
      stat.top_pops   = !top_open && (prec(top_ff) >= prec(op_ff));
      stat.emit_ok    = capped || !pend_valid_ff || out_free;
      stat.fin_ok     = !(pend_valid_ff || last_ff) || out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         open_ff       <= '0;
         operand_ff    <= 1'b0;
         sign_ff       <= 1'b1;
         err_ff        <= ST_OK;
         rcnt_ff       <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (cmd.load) begin
            err_ff  <= err_in;
            rcnt_ff <= '0;
         end
         if (do_emit) begin
            rcnt_ff       <= rcnt_ff + RCNT_W'(1);
            pend_valid_ff <= 1'b1;
         end
         if (do_push) begin
            count_ff <= count_ff + CNT_W'(1);
            if (op_ff == OP_OPEN) begin
               open_ff <= open_ff + CNT_W'(1);
            end
         end
         if (cmd.pop) begin
            count_ff <= count_ff - CNT_W'(1);
            if (top_open) begin
               open_ff <= open_ff - CNT_W'(1);
            end
         end
         if (cmd.set_operand) begin
            operand_ff <= 1'b1;
         end
         if (cmd.clr_operand) begin
            operand_ff <= 1'b0;
         end
         if (cmd.set_sign) begin
            sign_ff <= 1'b1;
         end
         if (cmd.clr_sign) begin
            sign_ff <= 1'b0;
         end
         if (move_emit || move_fin) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         if (cmd.finish) begin
            pend_valid_ff <= 1'b0;
            if (last_ff) begin
               count_ff   <= '0;
               open_ff    <= '0;
               operand_ff <= 1'b0;
               sign_ff    <= 1'b1;
               err_ff     <= ST_OK;
               rcnt_ff    <= '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         char_ff <= req_tdata;
         last_ff <= req_tlast;
         kind_ff <= req_kind;
         op_ff   <= req_op;
      end
      if (do_emit) begin
         pend_char_ff <= emit_char;
      end
      if (move_emit) begin
         out_char_ff   <= pend_char_ff;
         out_last_ff   <= 1'b0;
         out_status_ff <= err_ff;
      end
      if (move_fin) begin
         out_char_ff   <= pend_valid_ff ? pend_char_ff : CH_NUL;
         out_last_ff   <= last_ff;
         out_status_ff <= err_ff;
      end
   end

   // operator stack with a registered copy of the top entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         stack_ff[count_ff[IDX_W-1:0]] <= op_ff;
         top_ff                        <= op_ff;
      end
      if (cmd.pop && count_ff >= CNT_W'(2)) begin
         top_ff <= stack_ff[below_cnt[IDX_W-1:0]];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_char_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_status_ff;

   `I2P_CHECK(a_count_bound, clock, reset, count_ff <= CNT_W'(STACK_DEPTH), "stack count beyond depth")
   `I2P_CHECK(a_open_in_stack, clock, reset, open_ff <= count_ff, "open paren count above stack count")
   `I2P_CHECK(a_result_cap, clock, reset, rcnt_ff <= RCNT_W'(MAX_RESULTS), "result count beyond limit")
   `I2P_CHECK_NEXT(a_last_clears, clock, reset, cmd.finish && last_ff && stat.fin_ok, count_ff == '0 && err_ff == ST_OK && !pend_valid_ff && out_valid_ff && out_last_ff, "expression end left state behind")

endmodule

[sv/infix_to_postfix_converter.sv]
// an accepted operand character reaches rsp through the input, pending and output registers
// a new character is accepted only once the previous one is finished; the stack
//   pops one operator at a time, and each popped operator is followed by a space
// the final character also flushes the stack: each operator left is emitted, each open paren left dropped
// reset: synchronous, active high; clears counts, flags, status and the pending and
//   output valid bits; operator stack contents stay undefined and are never read unwritten
module infix_to_postfix_converter (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_char
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic       rsp_tlast,
   output logic [1:0] rsp_tuser    // [1:0] status
);
   import i2p_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   i2p_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   i2p_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[test/tb.sv]
module tb;
   import i2p_pkg::*;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      status_type st;
   } rsp_item_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } char_item_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] in_char
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] out_char
   logic       rsp_tlast;
   logic [1:0] rsp_tuser;           // [1:0] status

   infix_to_postfix_converter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // shunting-yard state mirrored on the testbench side
   opcode_type op_stack [STACK_DEPTH];
   int         op_count;
   bit         operand_open;
   bit         sign_ok;
   status_type expr_status;

   rsp_item_type  step_out[$];
   rsp_item_type  postfix_q[$];
   char_item_type infix_q[$];
   logic [7:0]    expr_buf[$];

   int   idle_mode;   // 0 none, 1 sender gaps, 2 receiver stalls, 3 both
   logic req_taken = 1'b0;
   int   errors = 0;
   int   chars_sent = 0;
   int   rsp_checked = 0;
   int   exprs_by_status [4];

   function automatic void reset_state();
      op_count     = 0;
      operand_open = 0;
      sign_ok      = 1;
      expr_status  = ST_OK;
   endfunction

   function automatic void put_char(logic [7:0] c);
      rsp_item_type r;
      if (step_out.size() < MAX_RESULTS) begin
         r.ch   = c;
         r.last = 1'b0;
         r.st   = ST_OK;
         step_out.push_back(r);
      end
   endfunction

   function automatic void put_op(opcode_type op);
      case (op)
         OP_ADD:  put_char(CH_ADD);
         OP_SUB:  put_char(CH_SUB);
         OP_MUL:  put_char(CH_MUL);
         OP_DIV:  put_char(CH_DIV);
         default: put_char(CH_OPEN);
      endcase
      put_char(CH_SPACE);
   endfunction

   function automatic int op_rank(opcode_type op);
      if (op == OP_MUL || op == OP_DIV) return 2;
      if (op == OP_ADD || op == OP_SUB) return 1;
      return 0;
   endfunction

   // only the first error of an expression sticks
   function automatic void note_error(status_type e);
      if (expr_status == ST_OK) expr_status = e;
   endfunction

   function automatic void push_op(opcode_type op);
      if (op_count >= STACK_DEPTH) begin
         note_error(ST_OVERFLOW);
      end else begin
         op_stack[op_count] = op;
         op_count++;
      end
   endfunction

   function automatic void close_token();
      if (operand_open) begin
         put_char(CH_SPACE);
         operand_open = 0;
      end
   endfunction

   // postfix items caused by one infix character
   function automatic void convert_char(logic [7:0] ch, logic last);
      opcode_type op;
      bit         is_op;
      bit         is_close;
      bit         found;
      opcode_type t;
      step_out.delete();
      op       = OP_OPEN;
      is_op    = 1;
      is_close = 0;
      case (ch)
         CH_OPEN:  op = OP_OPEN;
         CH_CLOSE: is_close = 1;
         CH_ADD:   op = OP_ADD;
         CH_MUL:   op = OP_MUL;
         CH_DIV:   op = OP_DIV;
         CH_SUB: begin
            if (sign_ok) is_op = 0;
            else op = OP_SUB;
         end
         default:  is_op = 0;
      endcase
      if (!is_op) begin
         put_char(ch);
         operand_open = 1;
         sign_ok      = 0;
      end else begin
         close_token();
         if (is_close) begin
            found = 0;
            while (op_count > 0 && !found) begin
               op_count--;
               t = op_stack[op_count];
               if (t == OP_OPEN) found = 1;
               else put_op(t);
            end
            if (!found) note_error(ST_UNMATCHED_CLOSE);
            sign_ok = 0;
         end else if (op == OP_OPEN) begin
            push_op(OP_OPEN);
            sign_ok = 1;
         end else begin
            while (op_count > 0 && op_stack[op_count-1] != OP_OPEN &&
                   op_rank(op_stack[op_count-1]) >= op_rank(op)) begin
               op_count--;
               put_op(op_stack[op_count]);
            end
            push_op(op);
            sign_ok = 0;
         end
      end
      if (last) begin
         close_token();
         while (op_count > 0) begin
            op_count--;
            if (op_stack[op_count] == OP_OPEN) note_error(ST_UNMATCHED_OPEN);
            else put_op(op_stack[op_count]);
         end
         // a final step with nothing to say still carries last and status
         if (step_out.size() == 0) put_char(CH_NUL);
         step_out[step_out.size()-1].last = 1'b1;
         exprs_by_status[expr_status]++;
      end
      foreach (step_out[i]) begin
         step_out[i].st = expr_status;
         postfix_q.push_back(step_out[i]);
      end
      if (last) reset_state();
   endfunction

   // stimulus building
   function automatic void commit_expr();
      char_item_type c;
      foreach (expr_buf[i]) begin
         c.ch   = expr_buf[i];
         c.last = (i == expr_buf.size() - 1);
         infix_q.push_back(c);
      end
      chars_sent += expr_buf.size();
      expr_buf.delete();
   endfunction

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) expr_buf.push_back(s[i]);
   endfunction

   function automatic void gen_operand();
      repeat ($urandom_range(1, 3)) begin
         if ($urandom_range(0, 1)) expr_buf.push_back(8'(8'h61 + $urandom_range(0, 25)));
         else expr_buf.push_back(8'(8'h30 + $urandom_range(0, 9)));
      end
   endfunction

   function automatic void gen_binary_op();
      case ($urandom_range(0, 3))
         0:       expr_buf.push_back(CH_ADD);
         1:       expr_buf.push_back(CH_SUB);
         2:       expr_buf.push_back(CH_MUL);
         default: expr_buf.push_back(CH_DIV);
      endcase
   endfunction

   function automatic void gen_factor(int depth);
      if (depth < 3 && $urandom_range(0, 3) == 0) begin
         expr_buf.push_back(CH_OPEN);
         if ($urandom_range(0, 3) == 0) expr_buf.push_back(CH_SUB);
         gen_sum(depth + 1);
         expr_buf.push_back(CH_CLOSE);
      end else begin
         gen_operand();
      end
   endfunction

   function automatic void gen_sum(int depth);
      gen_factor(depth);
      repeat ($urandom_range(0, 3)) begin
         gen_binary_op();
         gen_factor(depth);
      end
   endfunction

   function automatic void gen_well_formed();
      if ($urandom_range(0, 3) == 0) expr_buf.push_back(CH_SUB);
      gen_sum(0);
   endfunction

   // nesting around the stack depth, often past it
   function automatic void gen_deep();
      int k;
      k = $urandom_range(STACK_DEPTH - 3, STACK_DEPTH + 2);
      repeat (k) begin
         expr_buf.push_back(CH_OPEN);
         if ($urandom_range(0, 1)) begin
            gen_operand();
            gen_binary_op();
         end
      end
      gen_operand();
      repeat ($urandom_range(0, k)) expr_buf.push_back(CH_CLOSE);
   endfunction

   function automatic void gen_noise();
      repeat ($urandom_range(1, 6)) begin
         case ($urandom_range(0, 3))
            0:       expr_buf.push_back(CH_OPEN);
            1:       expr_buf.push_back(CH_CLOSE);
            2:       expr_buf.push_back(CH_SUB);
            default: expr_buf.push_back(8'($urandom_range(0, 255)));
         endcase
      end
   endfunction

   function automatic void gen_broken();
      gen_well_formed();
      if (expr_buf.size() > 1 && $urandom_range(0, 1))
         expr_buf.delete($urandom_range(0, expr_buf.size() - 1));
      else
         expr_buf.insert($urandom_range(0, expr_buf.size()), CH_CLOSE);
   endfunction

   function automatic void fill_phase(int n_chars);
      int start;
      int kind;
      start = chars_sent;
      gen_deep();
      commit_expr();
      while (chars_sent - start < n_chars) begin
         kind = $urandom_range(0, 9);
         if (kind <= 5) gen_well_formed();
         else if (kind == 6) gen_deep();
         else if (kind == 7) gen_noise();
         else gen_broken();
         commit_expr();
      end
   endfunction

   // driver: inputs move on the falling edge
   always @(negedge clock) begin : driver
      char_item_type item;
      logic          gap;
      logic          stall;
      gap   = (idle_mode == 1 && $urandom_range(0, 99) < 81) ||
              (idle_mode == 3 && $urandom_range(0, 99) < 13);
      stall = (idle_mode == 2 && $urandom_range(0, 99) < 81) ||
              (idle_mode == 3 && $urandom_range(0, 99) < 13);
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (infix_q.size() != 0 && !gap) begin
            item = infix_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= item.ch;
            req_tlast  <= item.last;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= !stall;
   end

   // monitor: handshakes sampled on the rising edge
   always @(posedge clock) begin : monitor
      rsp_item_type want;
      req_taken <= req_tvalid && req_tready && !reset;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (postfix_q.size() == 0) begin
               $display("%0t: unexpected item, expected none, actual ch=%h last=%b status=%0d",
                        $time, rsp_tdata, rsp_tlast, rsp_tuser);
               errors++;
            end else begin
               want = postfix_q.pop_front();
               rsp_checked++;
               if (rsp_tdata !== want.ch || rsp_tlast !== want.last ||
                   rsp_tuser !== want.st) begin
                  $display("%0t: mismatch, expected ch=%h last=%b status=%0d, actual ch=%h last=%b status=%0d",
                           $time, want.ch, want.last, want.st,
                           rsp_tdata, rsp_tlast, rsp_tuser);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready) convert_char(req_tdata, req_tlast);
      end
   end

   initial begin
      #(12 * 600000);
      $display("tb: failure");
      $finish;
   end

   initial begin
      foreach (exprs_by_status[i]) exprs_by_status[i] = 0;
      reset_state();
      idle_mode = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // signs, every operator and parens, then unmatched close, unmatched open and byte extremes
      add_text("-a+(-b)-c*d/e");
      commit_expr();
      add_text(")");
      commit_expr();
      add_text("(a");
      commit_expr();
      expr_buf.push_back(8'hff);
      expr_buf.push_back(8'h00);
      commit_expr();
      while (infix_q.size() != 0 || req_tvalid || postfix_q.size() != 0)
         @(posedge clock);

      for (int phase = 0; phase < 4; phase++) begin
         idle_mode = phase;
         fill_phase(55);
         while (infix_q.size() != 0 || req_tvalid || postfix_q.size() != 0)
            @(posedge clock);
      end

      repeat (10) @(posedge clock);
      $display("run: %0d characters in, %0d postfix items checked, four flow-control phases",
               chars_sent, rsp_checked);
      $display("run: expressions ok %0d, overflow %0d, unmatched close %0d, unmatched open %0d",
               exprs_by_status[0], exprs_by_status[1], exprs_by_status[2],
               exprs_by_status[3]);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
